// File: rtl/rrc_pkg.sv
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared codes for the ray rectangle clipper: result status codes, endpoint
// kinds and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rrc_pkg;

   // Result status of one clipped line.
   typedef enum logic [1:0] {
      STAT_NONE     = 2'd0,
      STAT_VISIBLE  = 2'd1,
      STAT_ZERO_DIR = 2'd2
   } stat_type;

   // Which constraint produced a clipped endpoint.
   typedef enum logic [1:0] {
      KIND_BASE  = 2'd0,
      KIND_XEDGE = 2'd1,
      KIND_YEDGE = 2'd2
   } kind_type;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_X_MIN = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_X_MAX = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_Y_MIN = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_Y_MAX = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BOTH  = 3'd4;

endpackage

`default_nettype wire

// File: rtl/ray_rectangle_clipper_top.sv
// ----------------------------------------------------------------------------
// ray_rectangle_clipper_top
// Clips a line or ray (base point plus direction) to the configured view
// rectangle and returns a status and the two endpoints of the visible part.
// ----------------------------------------------------------------------------
// Usage:
//   A line enters on the req_ channel (valid/ready) and one result leaves on
//   the rsp_ channel (valid/ready) for every line, in order. The view edges and
//   the ray/line mode are written on the csr_ port while the block is idle.
//   One line can be accepted every cycle while the receiver takes results. The
//   depth comes from the endpoint divider, which resolves one quotient
//   bit per stage; ahead of it sit an edge-setup stage, a cross-product stage,
//   a compare-and-select stage and the offset multiplier stage.
//   When the receiver stalls, the whole pipeline holds and req_ready drops
//   while a result waits (req_ready = !rsp_valid || rsp_ready).
//   Reset empties the pipeline and loads the default view rectangle
//   [0, 1.0] x [0, 1.0] in ray mode.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_rectangle_clipper_top import rrc_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_base_x,
   input  logic signed [COORD_WIDTH-1:0] req_base_y,
   input  logic signed [COORD_WIDTH-1:0] req_dir_x,
   input  logic signed [COORD_WIDTH-1:0] req_dir_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_clip_status,
   output logic signed [COORD_WIDTH-1:0] rsp_start_x,
   output logic signed [COORD_WIDTH-1:0] rsp_start_y,
   output logic signed [COORD_WIDTH-1:0] rsp_end_x,
   output logic signed [COORD_WIDTH-1:0] rsp_end_y,
   input  logic                          csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [COORD_WIDTH-1:0]        csr_wdata
);

   localparam int W  = COORD_WIDTH;
   localparam int PW = 2 * W;
   localparam logic [W-1:0] ONE_Q = W'(64'd65536);

   // One crossing parameter t = +-num / den, with its edge coordinate.
   typedef struct packed {
      logic         neg;
      logic [W-1:0] num;
      logic [W-1:0] edg;
   } bnd_type;

   // Edge setup results.
   typedef struct packed {
      bnd_type      xent;
      bnd_type      xext;
      bnd_type      yent;
      bnd_type      yext;
      logic [W-1:0] dxm;
      logic [W-1:0] dym;
      logic         dxn;
      logic         dyn;
      logic         xv;
      logic         yv;
      logic         ok;
      logic         ray;
      logic         zero;
      logic [W-1:0] x0;
      logic [W-1:0] y0;
   } s1_type;

   // Cross products for the parameter compares.
   typedef struct packed {
      s1_type        b;
      logic [PW-1:0] pa1;
      logic [PW-1:0] pa2;
      logic [PW-1:0] pb1;
      logic [PW-1:0] pb2;
      logic [PW-1:0] pc1;
      logic [PW-1:0] pc2;
      logic [PW-1:0] pd1;
      logic [PW-1:0] pd2;
   } s2_type;

   // One endpoint before the offset multiply.
   typedef struct packed {
      logic         neg;
      logic         swap;
      logic [W-1:0] fix;
      logic [W-1:0] base;
      logic [W-1:0] den;
      logic [W-1:0] num;
      logic [W-1:0] dmag;
   } mep_type;

   typedef struct packed {
      stat_type status;
      mep_type  a;
      mep_type  b;
   } m_type;

   // One endpoint inside the divider.
   typedef struct packed {
      logic         neg;
      logic         swap;
      logic [W-1:0] fix;
      logic [W-1:0] base;
      logic [W-1:0] den;
      logic [W-1:0] rem;
      logic [W-1:0] quo;
      logic [W-1:0] dvd;
   } dl_type;

   typedef struct packed {
      stat_type status;
      dl_type   a;
      dl_type   b;
   } ds_type;

   // Configuration registers.
   logic signed [W-1:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic                both_ff;

   // Pipeline registers.
   logic   adv;
   logic   v1_ff, v2_ff, v3_ff;
   logic   dv_ff [0:W];
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   m_type  m_ff, m_in;
   ds_type ds_ff [0:W];
   ds_type ds_in;
   logic                rsp_valid_ff;
   stat_type            status_ff;
   logic signed [W-1:0] sx_ff, sy_ff, ex_ff, ey_ff;

   // Crossing parameter of the line with one edge.
   function automatic bnd_type mk_bnd(logic signed [W-1:0] e, logic signed [W-1:0] p,
                                      logic dneg);
      logic         below;
      logic [W-1:0] n;
      bnd_type      r;
      below = e < p;
      n = below ? W'(p - e) : W'(e - p);
      r.num = n;
      r.edg = e;
      r.neg = (below != dneg) && (n != '0);
      return r;
   endfunction

   // t(a) > t(b), given pa = a.num * b.den and pb = b.num * a.den.
   function automatic logic t_gt(logic sa, logic sb, logic [PW-1:0] pa, logic [PW-1:0] pb);
      logic r;
      if (sa != sb) begin
         r = sb;
      end else if (sa) begin
         r = pa < pb;
      end else begin
         r = pa > pb;
      end
      return r;
   endfunction

   function automatic logic t_pos(bnd_type b);
      return !b.neg && (b.num != '0);
   endfunction

   // t(a) < t(b) for two bounds that share a denominator.
   function automatic logic t_lt_same(bnd_type a, bnd_type b);
      logic signed [W:0] va, vb;
      va = a.neg ? -$signed({1'b0, a.num}) : $signed({1'b0, a.num});
      vb = b.neg ? -$signed({1'b0, b.num}) : $signed({1'b0, b.num});
      return va < vb;
   endfunction

   // Operands of the endpoint computation for one bound.
   function automatic mep_type mk_ep(kind_type k, bnd_type b, s1_type s);
      mep_type r;
      case (k)
         KIND_XEDGE: begin
            r.fix  = b.edg;
            r.base = s.y0;
            r.den  = s.dxm;
            r.num  = b.num;
            r.dmag = s.dym;
            r.neg  = b.neg ^ s.dyn;
            r.swap = 1'b0;
         end
         KIND_YEDGE: begin
            r.fix  = b.edg;
            r.base = s.x0;
            r.den  = s.dym;
            r.num  = b.num;
            r.dmag = s.dxm;
            r.neg  = b.neg ^ s.dxn;
            r.swap = 1'b1;
         end
         default: begin
            r.fix  = s.x0;
            r.base = s.y0;
            r.den  = W'(1);
            r.num  = '0;
            r.dmag = '0;
            r.neg  = 1'b0;
            r.swap = 1'b0;
         end
      endcase
      return r;
   endfunction

   function automatic dl_type dl_init(mep_type m);
      logic [PW-1:0] n;
      dl_type        r;
      n = PW'(m.num) * PW'(m.dmag);
      r.neg  = m.neg;
      r.swap = m.swap;
      r.fix  = m.fix;
      r.base = m.base;
      r.den  = m.den;
      r.rem  = n[PW-1:W];
      r.quo  = '0;
      r.dvd  = n[W-1:0];
      return r;
   endfunction

   // One restoring division step.
   function automatic dl_type dl_step(dl_type d);
      logic [W:0] r2;
      logic       ge;
      dl_type     r;
      r2 = {d.rem, d.dvd[W-1]};
      ge = r2 >= {1'b0, d.den};
      r = d;
      r.rem = ge ? W'(r2 - {1'b0, d.den}) : r2[W-1:0];
      r.quo = {d.quo[W-2:0], ge};
      r.dvd = {d.dvd[W-2:0], 1'b0};
      return r;
   endfunction

   // Round to nearest and apply the offset; returns {x, y}.
   function automatic logic [PW-1:0] dl_final(dl_type d);
      logic         up;
      logic [W-1:0] q, along;
      up = {d.rem, 1'b0} >= {1'b0, d.den};
      q = d.quo + W'(up);
      along = d.neg ? d.base - q : d.base + q;
      return d.swap ? {along, d.fix} : {d.fix, along};
   endfunction

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= '0;
         x_max_ff <= ONE_Q;
         y_min_ff <= '0;
         y_max_ff <= ONE_Q;
         both_ff  <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_X_MIN: x_min_ff <= csr_wdata;
            REG_X_MAX: x_max_ff <= csr_wdata;
            REG_Y_MIN: y_min_ff <= csr_wdata;
            REG_Y_MAX: y_max_ff <= csr_wdata;
            REG_BOTH:  both_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The whole pipeline moves when the output register is free.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // Stage 1: sort the edges and form the four crossing parameters.
   always_comb begin
      logic signed [W-1:0] xlo, xhi, ylo, yhi;
      logic                dxn, dyn, xv, yv, okx, oky;
      xlo = (x_min_ff < x_max_ff) ? x_min_ff : x_max_ff;
      xhi = (x_min_ff < x_max_ff) ? x_max_ff : x_min_ff;
      ylo = (y_min_ff < y_max_ff) ? y_min_ff : y_max_ff;
      yhi = (y_min_ff < y_max_ff) ? y_max_ff : y_min_ff;
      dxn = req_dir_x[W-1];
      dyn = req_dir_y[W-1];
      xv  = req_dir_x != '0;
      yv  = req_dir_y != '0;
      okx = xv || (req_base_x >= xlo && req_base_x <= xhi);
      oky = yv || (req_base_y >= ylo && req_base_y <= yhi);
      s1_in.xent = mk_bnd(dxn ? xhi : xlo, req_base_x, dxn);
      s1_in.xext = mk_bnd(dxn ? xlo : xhi, req_base_x, dxn);
      s1_in.yent = mk_bnd(dyn ? yhi : ylo, req_base_y, dyn);
      s1_in.yext = mk_bnd(dyn ? ylo : yhi, req_base_y, dyn);
      s1_in.dxm  = dxn ? W'(-req_dir_x) : req_dir_x;
      s1_in.dym  = dyn ? W'(-req_dir_y) : req_dir_y;
      s1_in.dxn  = dxn;
      s1_in.dyn  = dyn;
      s1_in.xv   = xv;
      s1_in.yv   = yv;
      s1_in.ok   = okx && oky;
      s1_in.ray  = !both_ff;
      s1_in.zero = !xv && !yv;
      s1_in.x0   = req_base_x;
      s1_in.y0   = req_base_y;
   end

   // Stage 2: cross products of numerators and denominators.
   always_comb begin
      s2_in.b   = s1_ff;
      s2_in.pa1 = PW'(s1_ff.xent.num) * PW'(s1_ff.dym);
      s2_in.pa2 = PW'(s1_ff.yent.num) * PW'(s1_ff.dxm);
      s2_in.pb1 = PW'(s1_ff.xext.num) * PW'(s1_ff.dym);
      s2_in.pb2 = PW'(s1_ff.yext.num) * PW'(s1_ff.dxm);
      s2_in.pc1 = PW'(s1_ff.yext.num) * PW'(s1_ff.dxm);
      s2_in.pc2 = PW'(s1_ff.xent.num) * PW'(s1_ff.dym);
      s2_in.pd1 = PW'(s1_ff.xext.num) * PW'(s1_ff.dym);
      s2_in.pd2 = PW'(s1_ff.yent.num) * PW'(s1_ff.dxm);
   end

   // Stage 3: pick the entry and exit bounds, decide visibility, order ends.
   always_comb begin
      kind_type lo_k, hi_k;
      logic     lo_has, lt, fwd;
      bnd_type  lo_b, hi_b;
      s1_type   s;
      mep_type  lo_e, hi_e;
      s = s2_ff.b;
      lo_k   = KIND_BASE;
      lo_has = s.ray;
      if (s.xv && (!lo_has || t_pos(s.xent))) begin
         lo_k   = KIND_XEDGE;
         lo_has = 1'b1;
      end
      if (s.yv) begin
         if (!lo_has) begin
            lo_k = KIND_YEDGE;
         end else if (lo_k == KIND_BASE) begin
            if (t_pos(s.yent)) begin
               lo_k = KIND_YEDGE;
            end
         end else if (t_gt(s.yent.neg, s.xent.neg, s2_ff.pa2, s2_ff.pa1)) begin
            lo_k = KIND_YEDGE;
         end
      end
      hi_k = KIND_XEDGE;
      if (s.yv && (!s.xv || t_gt(s.xext.neg, s.yext.neg, s2_ff.pb1, s2_ff.pb2))) begin
         hi_k = KIND_YEDGE;
      end
      // Entry strictly before exit means a segment of nonzero length.
      if (lo_k == KIND_BASE) begin
         lt = (hi_k == KIND_XEDGE) ? t_pos(s.xext) : t_pos(s.yext);
      end else if (lo_k == KIND_XEDGE) begin
         lt = (hi_k == KIND_XEDGE) ? t_lt_same(s.xent, s.xext)
                                   : t_gt(s.yext.neg, s.xent.neg, s2_ff.pc1, s2_ff.pc2);
      end else begin
         lt = (hi_k == KIND_XEDGE) ? t_gt(s.xext.neg, s.yent.neg, s2_ff.pd1, s2_ff.pd2)
                                   : t_lt_same(s.yent, s.yext);
      end
      lo_b = (lo_k == KIND_XEDGE) ? s.xent : s.yent;
      hi_b = (hi_k == KIND_XEDGE) ? s.xext : s.yext;
      lo_e = mk_ep(lo_k, lo_b, s);
      hi_e = mk_ep(hi_k, hi_b, s);
      fwd  = (s.yv && !s.dyn) || (!s.yv && !s.dxn);
      if (s.zero) begin
         m_in.status = STAT_ZERO_DIR;
      end else if (s.ok && lt) begin
         m_in.status = STAT_VISIBLE;
      end else begin
         m_in.status = STAT_NONE;
      end
      m_in.a = fwd ? lo_e : hi_e;
      m_in.b = fwd ? hi_e : lo_e;
   end

   // Stage 4: offset numerators, loaded into the divider.
   always_comb begin
      ds_in.status = m_ff.status;
      ds_in.a      = dl_init(m_ff.a);
      ds_in.b      = dl_init(m_ff.b);
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= W; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff    <= req_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         dv_ff[0] <= v3_ff;
         for (int k = 1; k <= W; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         rsp_valid_ff <= dv_ff[W];
      end
   end

   // Payload registers, including one divider stage per quotient bit.
   always_ff @(posedge clock) begin
      logic [PW-1:0] pa, pb;
      logic          vis;
      if (adv) begin
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         m_ff     <= m_in;
         ds_ff[0] <= ds_in;
         for (int k = 1; k <= W; k++) begin
            ds_ff[k].status <= ds_ff[k-1].status;
            ds_ff[k].a      <= dl_step(ds_ff[k-1].a);
            ds_ff[k].b      <= dl_step(ds_ff[k-1].b);
         end
         pa  = dl_final(ds_ff[W].a);
         pb  = dl_final(ds_ff[W].b);
         vis = ds_ff[W].status == STAT_VISIBLE;
         status_ff <= ds_ff[W].status;
         sx_ff     <= vis ? pa[PW-1:W] : '0;
         sy_ff     <= vis ? pa[W-1:0]  : '0;
         ex_ff     <= vis ? pb[PW-1:W] : '0;
         ey_ff     <= vis ? pb[W-1:0]  : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_clip_status = status_ff;
   assign rsp_start_x     = sx_ff;
   assign rsp_start_y     = sy_ff;
   assign rsp_end_x       = ex_ff;
   assign rsp_end_y       = ey_ff;

endmodule

`default_nettype wire

// File: rtl/rrc_checker.sv
// ----------------------------------------------------------------------------
// rrc_checker
// Port-level checks of the ray rectangle clipper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rrc_checker import rrc_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [1:0]             rsp_clip_status,
   input logic [COORD_WIDTH-1:0] rsp_start_x,
   input logic [COORD_WIDTH-1:0] rsp_start_y,
   input logic [COORD_WIDTH-1:0] rsp_end_x,
   input logic [COORD_WIDTH-1:0] rsp_end_y
);

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_clip_status)
         && $stable(rsp_start_x) && $stable(rsp_start_y)
         && $stable(rsp_end_x) && $stable(rsp_end_y))
      else $error("stalled result changed");

   // Results without a visible segment carry zero endpoints.
   a_zero_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clip_status != STAT_VISIBLE |->
         rsp_start_x == '0 && rsp_start_y == '0 && rsp_end_x == '0 && rsp_end_y == '0)
      else $error("endpoints not cleared on invisible result");

   // The start endpoint never lies above the end endpoint.
   a_end_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clip_status == STAT_VISIBLE |->
         $signed(rsp_start_y) <= $signed(rsp_end_y))
      else $error("endpoints out of order");

   // An empty output register never blocks the input.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

endmodule

bind ray_rectangle_clipper_top rrc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rrc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_clip_status (rsp_clip_status),
   .rsp_start_x     (rsp_start_x),
   .rsp_start_y     (rsp_start_y),
   .rsp_end_x       (rsp_end_x),
   .rsp_end_y       (rsp_end_y)
);

`default_nettype wire
